// ===== design/c2p_pkg.sv =====
// ----------------------------------------------------------------------------
// c2p_pkg: shared types, constants and angle table
// Stage payload types and the CORDIC arctangent constants of the cartesian
// to polar radar block.
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int ANG_FRAC          = 60;
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int SQRT_CELLS        = 32;
  localparam int DIV_CELLS         = 64;
  localparam int XY_W              = 36;
  localparam int BEAR_W            = 19;
  localparam int RATE_W            = 33;

  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

  typedef struct packed {
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] mag;
    logic        neg;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] dq;
    logic [31:0] d;
    logic        neg;
  } dv_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [63:0]     z;
  } cd_t;

  function automatic logic [63:0] atan_inv5();
    logic [63:0] p;
    logic [63:0] acc;
    p   = (64'd1 << ANG_FRAC) / 5;
    acc = p;
    for (int k = 1; k < 64; k++) begin
      p = p / 25;
      if (p == 64'd0) break;
      if (k[0]) acc = acc - p / 64'(2 * k + 1);
      else acc = acc + p / 64'(2 * k + 1);
    end
    return acc;
  endfunction

  function automatic logic [63:0] atan_inv239();
    logic [63:0] p;
    logic [63:0] acc;
    p   = (64'd1 << ANG_FRAC) / 239;
    acc = p;
    for (int k = 1; k < 64; k++) begin
      p = p / 57121;
      if (p == 64'd0) break;
      if (k[0]) acc = acc - p / 64'(2 * k + 1);
      else acc = acc + p / 64'(2 * k + 1);
    end
    return acc;
  endfunction

  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] acc;
    logic [63:0] t;
    int          e;
    acc = 64'd0;
    if (i == 0) begin
      acc = 64'd4 * atan_inv5() - atan_inv239();
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = i * (2 * k + 1);
        if (e > ANG_FRAC) break;
        t = (64'd1 << (ANG_FRAC - e)) / 64'(2 * k + 1);
        if (k % 2 == 1) acc = acc - t;
        else acc = acc + t;
      end
    end
    return acc;
  endfunction

  localparam logic [63:0] PI_Q   = 64'd4 * atan_entry(0);
  localparam logic [63:0] HALF_Q = PI_Q >> 1;

endpackage

// ===== design/c2p_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// c2p_sqrt_cell: one bit of the integer square root
// Restoring square root step for test bit 4^(31-K); carries the range-rate
// numerator alongside.
// ----------------------------------------------------------------------------
module c2p_sqrt_cell #(
  parameter int K = 0
) (
  input  logic          clk,
  input  logic          en,
  input  c2p_pkg::sq_t  d_in,
  output c2p_pkg::sq_t  d_out
);
  import c2p_pkg::*;

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * K);

  sq_t         d_r;
  sq_t         d_nxt;
  logic [63:0] trial;

  always_comb begin
    trial = d_in.r + BIT;
    d_nxt = d_in;
    if (d_in.s >= trial) begin
      d_nxt.s = d_in.s - trial;
      d_nxt.r = (d_in.r >> 1) + BIT;
    end else begin
      d_nxt.r = d_in.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== design/c2p_div_cell.sv =====
// ----------------------------------------------------------------------------
// c2p_div_cell: one quotient bit of the range-rate division
// Restoring division step; the dividend shifts out as quotient bits shift in.
// ----------------------------------------------------------------------------
module c2p_div_cell (
  input  logic          clk,
  input  logic          en,
  input  c2p_pkg::dv_t  d_in,
  output c2p_pkg::dv_t  d_out
);
  import c2p_pkg::*;

  dv_t         d_r;
  dv_t         d_nxt;
  logic [32:0] part;
  logic [32:0] diff;
  logic        qbit;

  always_comb begin
    part  = {d_in.rem, d_in.dq[63]};
    diff  = part - {1'b0, d_in.d};
    qbit  = (part >= {1'b0, d_in.d});
    d_nxt = d_in;
    d_nxt.rem = qbit ? diff[31:0] : part[31:0];
    d_nxt.dq  = {d_in.dq[62:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== design/c2p_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// c2p_cordic_cell: one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-S) and accumulates the angle.
// ----------------------------------------------------------------------------
module c2p_cordic_cell #(
  parameter int S = 0
) (
  input  logic          clk,
  input  logic          en,
  input  c2p_pkg::cd_t  d_in,
  output c2p_pkg::cd_t  d_out
);
  import c2p_pkg::*;

  localparam logic signed [63:0] ANG = $signed(atan_entry(S));

  cd_t                    d_r;
  cd_t                    d_nxt;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  always_comb begin
    dx = d_in.y >>> S;
    dy = d_in.x >>> S;
    if (d_in.y > 0) begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + ANG;
    end else begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== design/cartesian_to_polar_radar.sv =====
// Throughput: one request per cycle; the whole pipeline holds while a
// result waits and out_ready is low.
// Latency is set by the 32-cell square root row and 64-cell divider row.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// cartesian_to_polar_radar: range, bearing and range rate from a state vector
// Square root and divider rows of cells run in series, with the CORDIC row
// beside them, in one pipeline with a common advance enable.
// ----------------------------------------------------------------------------
module cartesian_to_polar_radar #(
  parameter int CORDIC_STAGES = c2p_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                in_pos_x,
  input  logic signed [31:0]                in_pos_y,
  input  logic signed [31:0]                in_vel_x,
  input  logic signed [31:0]                in_vel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [31:0]                       out_range_out,
  output logic signed [c2p_pkg::BEAR_W-1:0] out_bearing_out,
  output logic signed [c2p_pkg::RATE_W-1:0] out_range_rate_out,
  output logic                              out_zero_range
);
  import c2p_pkg::*;

  localparam int MAIN_LAT = SQRT_CELLS + DIV_CELLS + 3;
  localparam int ANG_DLY  = MAIN_LAT - 2 - CORDIC_STAGES;
  localparam int RND_SH   = ANG_FRAC - FRAC_BITS;

  logic adv;

  // stage A
  logic signed [31:0] px_r, py_r, vx_r, vy_r;
  ctl_t               ctl_a_r;
  ctl_t               ctl_sr [1:MAIN_LAT];

  // stage B
  logic signed [63:0] pxx_r, pyy_r, a_r, b_r;
  cd_t                cd0_nxt;

  // stage C
  logic signed [64:0] t_sum;
  sq_t                sq0_nxt;

  sq_t sq [0:SQRT_CELLS];
  dv_t dv [0:DIV_CELLS];
  cd_t cd [0:CORDIC_STAGES];

  // stage D
  logic [31:0] r_rnd;
  dv_t         dv0_nxt;

  // stage E
  logic signed [63:0]       zw;
  logic [63:0]              zm;
  logic [63:0]              zr;
  logic signed [BEAR_W-1:0] ang_nxt;
  logic signed [BEAR_W-1:0] ang_d_r [0:ANG_DLY];

  // output
  logic [63:0]              q;
  logic signed [RATE_W-1:0] rate;
  logic                     out_valid_r;
  logic [31:0]              range_r;
  logic signed [BEAR_W-1:0] bear_r;
  logic signed [RATE_W-1:0] rate_r;
  logic                     zero_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      for (int i = 1; i <= MAIN_LAT; i++) ctl_sr[i] <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      ctl_a_r.vld  <= in_valid;
      ctl_a_r.zero <= (in_pos_x == 32'sd0) && (in_pos_y == 32'sd0);
      ctl_sr[1]    <= ctl_a_r;
      for (int i = 2; i <= MAIN_LAT; i++) ctl_sr[i] <= ctl_sr[i-1];
      out_valid_r  <= ctl_sr[MAIN_LAT].vld;
    end
  end

  always_comb begin
    cd0_nxt.x = XY_W'(px_r);
    cd0_nxt.y = XY_W'(py_r);
    cd0_nxt.z = 64'sd0;
    if (px_r < 0) begin
      if (py_r >= 0) begin
        cd0_nxt.z = $signed(HALF_Q);
        cd0_nxt.x = XY_W'(py_r);
        cd0_nxt.y = -XY_W'(px_r);
      end else begin
        cd0_nxt.z = -$signed(HALF_Q);
        cd0_nxt.x = -XY_W'(py_r);
        cd0_nxt.y = XY_W'(px_r);
      end
    end
  end

  always_comb begin
    t_sum       = {a_r[63], a_r} + {b_r[63], b_r};
    sq0_nxt.s   = pxx_r + pyy_r;
    sq0_nxt.r   = 64'd0;
    sq0_nxt.neg = t_sum[64];
    sq0_nxt.mag = t_sum[64] ? 64'(-t_sum) : t_sum[63:0];
  end

  always_comb begin
    r_rnd       = sq[SQRT_CELLS].r[31:0] +
                  32'(sq[SQRT_CELLS].s > sq[SQRT_CELLS].r);
    dv0_nxt.rem = 32'd0;
    dv0_nxt.dq  = sq[SQRT_CELLS].mag + 64'(r_rnd >> 1);
    dv0_nxt.d   = r_rnd;
    dv0_nxt.neg = sq[SQRT_CELLS].neg;
  end

  always_comb begin
    zw = cd[CORDIC_STAGES].z;
    if (cd[CORDIC_STAGES].z > $signed(PI_Q)) zw = cd[CORDIC_STAGES].z - $signed(PI_Q << 1);
    else if (cd[CORDIC_STAGES].z < -$signed(PI_Q)) zw = cd[CORDIC_STAGES].z + $signed(PI_Q << 1);
    zm      = zw[63] ? 64'(-zw) : 64'(zw);
    zr      = (zm + (64'd1 << (RND_SH - 1))) >> RND_SH;
    ang_nxt = zw[63] ? -$signed(zr[BEAR_W-1:0]) : $signed(zr[BEAR_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      vx_r    <= in_vel_x;
      vy_r    <= in_vel_y;
      pxx_r   <= px_r * px_r;
      pyy_r   <= py_r * py_r;
      a_r     <= px_r * vx_r;
      b_r     <= py_r * vy_r;
      cd[0]   <= cd0_nxt;
      sq[0]   <= sq0_nxt;
      dv[0]   <= dv0_nxt;
      ang_d_r[0] <= ang_nxt;
      for (int i = 1; i <= ANG_DLY; i++) ang_d_r[i] <= ang_d_r[i-1];
    end
  end

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    c2p_sqrt_cell #(.K(k)) u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (sq[k]),
      .d_out (sq[k+1])
    );
  end

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    c2p_div_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (dv[k]),
      .d_out (dv[k+1])
    );
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    c2p_cordic_cell #(.S(k)) u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (cd[k]),
      .d_out (cd[k+1])
    );
  end

  always_comb begin
    q = dv[DIV_CELLS].dq;
    if (dv[DIV_CELLS].neg) begin
      rate = (q > 64'h1_0000_0000) ? -(RATE_W'(64'h1_0000_0000)) : -$signed(q[RATE_W-1:0]);
    end else begin
      rate = (q > 64'h0_FFFF_FFFF) ? $signed(RATE_W'(64'h0_FFFF_FFFF)) : $signed(q[RATE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r  <= ctl_sr[MAIN_LAT].zero;
      range_r <= ctl_sr[MAIN_LAT].zero ? 32'd0 : dv[DIV_CELLS].d;
      bear_r  <= ctl_sr[MAIN_LAT].zero ? '0 : ang_d_r[ANG_DLY];
      rate_r  <= ctl_sr[MAIN_LAT].zero ? '0 : rate;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_range_out      = range_r;
  assign out_bearing_out    = bear_r;
  assign out_range_rate_out = rate_r;
  assign out_zero_range     = zero_r;

endmodule

// ===== tb/radar_checker.sv =====
// ----------------------------------------------------------------------------
// radar_checker: measurement prediction and result comparison
// Watches the request and result channels, computes range, bearing and range
// rate for every accepted request and compares each result against the
// oldest pending prediction.
// ----------------------------------------------------------------------------
module radar_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [31:0]                in_pos_x,
  input  logic signed [31:0]                in_pos_y,
  input  logic signed [31:0]                in_vel_x,
  input  logic signed [31:0]                in_vel_y,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [31:0]                       out_range_out,
  input  logic signed [c2p_pkg::BEAR_W-1:0] out_bearing_out,
  input  logic signed [c2p_pkg::RATE_W-1:0] out_range_rate_out,
  input  logic                              out_zero_range,
  output int                                fail_count,
  output int                                pending
);
  import c2p_pkg::*;

  localparam int STAGES = CORDIC_STAGES_DEF;

  typedef struct packed {
    logic [31:0]        rng;
    logic [BEAR_W-1:0]  brg;
    logic [RATE_W-1:0]  rate;
    logic               zero;
  } meas_t;

  meas_t      meas_q[$];
  logic [63:0] arctan_lut[32];

  function automatic logic [63:0] series_atan_inv(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] acc;
    p   = (64'd1 << ANG_FRAC) / n;
    acc = p;
    for (int k = 1; k < 64; k++) begin
      p = p / (n * n);
      if (p == 0) break;
      if (k[0]) acc = acc - p / 64'(2 * k + 1);
      else acc = acc + p / 64'(2 * k + 1);
    end
    return acc;
  endfunction

  function automatic logic [63:0] series_atan_pow2(input int i);
    logic [63:0] acc;
    int e;
    acc = 0;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > ANG_FRAC) break;
      if (k[0]) acc = acc - ((64'd1 << (ANG_FRAC - e)) / 64'(2 * k + 1));
      else acc = acc + ((64'd1 << (ANG_FRAC - e)) / 64'(2 * k + 1));
    end
    return acc;
  endfunction

  initial begin
    arctan_lut[0] = 64'd4 * series_atan_inv(5) - series_atan_inv(239);
    for (int i = 1; i < 32; i++) arctan_lut[i] = series_atan_pow2(i);
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(input longint py, input longint px);
    longint x, y, z, t, dx, dy, pi_v;
    int s;
    pi_v = longint'(arctan_lut[0] * 4);
    x = px;
    y = py;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        z = pi_v / 2; x = y; y = -t;
      end else begin
        z = -(pi_v / 2); x = -y; y = t;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      s = i & 31;
      dx = y >>> s;
      dy = x >>> s;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + longint'(arctan_lut[s]);
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(arctan_lut[s]);
      end
    end
    if (z > pi_v) z = z - 2 * pi_v;
    else if (z < -pi_v) z = z + 2 * pi_v;
    return z;
  endfunction

  function automatic meas_t predict_measurement(input longint px, input longint py,
                                                input longint vx, input longint vy);
    meas_t m;
    logic [63:0] s, r, mag, q, am;
    longint a, b, t, z, ang, rate;
    logic neg;
    m = '0;
    if (px == 0 && py == 0) begin
      m.zero = 1'b1;
      return m;
    end
    s = 64'(px * px) + 64'(py * py);
    r = int_sqrt(s);
    if (s - r * r > r) r = r + 1;
    z = vector_angle(py, px);
    am = (z < 0) ? 64'(-z) : 64'(z);
    am = (am + (64'd1 << (ANG_FRAC - FRAC_BITS - 1))) >> (ANG_FRAC - FRAC_BITS);
    ang = (z < 0) ? -longint'(am) : longint'(am);
    a = px * vx;
    b = py * vy;
    if (a >= 0 && b >= 0) begin
      mag = 64'(a) + 64'(b); neg = 0;
    end else if (a < 0 && b < 0) begin
      mag = 64'(-a) + 64'(-b); neg = 1;
    end else begin
      t = a + b;
      neg = t < 0;
      mag = neg ? 64'(-t) : 64'(t);
    end
    q = (mag + r / 2) / r;
    if (neg) rate = (q > 64'h1_0000_0000) ? -64'sh1_0000_0000 : -longint'(q);
    else rate = (q > 64'hFFFF_FFFF) ? 64'shFFFF_FFFF : longint'(q);
    m.rng  = r[31:0];
    m.brg  = ang[BEAR_W-1:0];
    m.rate = rate[RATE_W-1:0];
    return m;
  endfunction

  always @(posedge clk) begin
    meas_t exp_m;
    if (rst_n) begin
      if (in_valid && in_ready)
        meas_q.push_back(predict_measurement(in_pos_x, in_pos_y, in_vel_x, in_vel_y));
      if (out_valid && out_ready) begin
        if (meas_q.size() == 0) begin
          $display("%0t: unexpected result range=%h", $time, out_range_out);
          fail_count++;
        end else begin
          exp_m = meas_q.pop_front();
          if (out_range_out !== exp_m.rng || out_bearing_out !== exp_m.brg ||
              out_range_rate_out !== exp_m.rate || out_zero_range !== exp_m.zero) begin
            $display("%0t: mismatch expected rng=%h brg=%h rate=%h zero=%b", $time,
                     exp_m.rng, exp_m.brg, exp_m.rate, exp_m.zero);
            $display("%0t:          actual   rng=%h brg=%h rate=%h zero=%b", $time,
                     out_range_out, out_bearing_out, out_range_rate_out, out_zero_range);
            fail_count++;
          end
        end
      end
      pending = meas_q.size();
    end
  end
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: cartesian to polar radar block
// Drives directed and random state vectors with random gaps and result
// back-pressure; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import c2p_pkg::*;

  localparam int N_RANDOM  = 800;
  localparam int LATENCY   = 100;
  localparam int MAX_CYCLES = 400000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [31:0]       in_pos_x, in_pos_y, in_vel_x, in_vel_y;
  logic                     out_valid;
  logic                     out_ready;
  logic [31:0]              out_range_out;
  logic signed [BEAR_W-1:0] out_bearing_out;
  logic signed [RATE_W-1:0] out_range_rate_out;
  logic                     out_zero_range;
  int                       fail_count;
  int                       pending;
  int                       cycle_count;
  int                       out_wait;

  cartesian_to_polar_radar dut (.*);

  radar_checker u_checker (.*);

  initial clk = 0;
  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(0, 6)) - 3);
      3, 4: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
      5: return 32'(signed'($urandom_range(0, 200)) - 100) <<< $urandom_range(0, 24);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] vx, input logic [31:0] vy);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_vel_x <= vx;
    in_vel_y <= vy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_ready <= 0;
      out_wait  <= $urandom_range(0, 12);
    end else if (out_valid && out_ready) begin
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      out_wait  <= w;
      out_ready <= (w == 0);
    end else if (out_wait > 0) begin
      if (out_wait == 1) out_ready <= 1;
      out_wait <= out_wait - 1;
    end else begin
      out_ready <= 1;
    end
  end

  initial begin
    logic [31:0] ext[4];
    rst_n = 0;
    in_valid = 0;
    in_pos_x = 0;
    in_pos_y = 0;
    in_vel_x = 0;
    in_vel_y = 0;
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_request(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(0, 0, 0, 0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_request(ext[i], ext[j], ext[j], ext[i]);
    send_request(32'hFFFF_0000, 0, 5, 7);
    send_request(32'hFFFF_0000, 32'hFFFF_FFFF, 0, 0);
    send_request(32'hFFFF_0000, 32'h0000_0001, 0, 0);
    send_request(0, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(1, 0, 32'h7FFF_FFFF, 0);
    send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    for (int n = 0; n < N_RANDOM; n++)
      send_request(pick_coord(), pick_coord(), $urandom, $urandom);
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
